/* rtl/bsfa_pkg.sv */
// ----------------------------------------------------------------------------
// bsfa_pkg: shared definitions of the line-current field accumulator
// Widths, command and status codes, the sequencer state type and the
// status bundle of the shared divide unit.
// ----------------------------------------------------------------------------
package bsfa_pkg;

  // Wire table size and the widths that follow from it.
  localparam int MAX_WIRES = 64;
  localparam int IDX_W     = $clog2(MAX_WIRES);
  localparam int CNT_W     = $clog2(MAX_WIRES + 1);

  // Field widths.
  localparam int CMD_W    = 2;
  localparam int POS_W    = 16;
  localparam int AMPS_W   = 15;
  localparam int STATUS_W = 2;
  localparam int FIELD_W  = 32;
  localparam int MAG_W    = 31;
  localparam int DIR_W    = 16;
  localparam int SCALE_W  = 16;
  localparam int CUT_W    = 15;

  // One table entry holds x, y and the current.
  localparam int ENTRY_W = 2 * POS_W + AMPS_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF      = 1'd1;
  localparam logic [SCALE_W-1:0]   SCALE_RESET     = 16'd655;
  localparam logic [CUT_W-1:0]     CUTOFF_RESET    = 15'd655;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

  // Divide unit: unsigned numerator, divisor and quotient widths.
  localparam int DIV_NUM_W = 50;
  localparam int DIV_DEN_W = 34;
  localparam int DIV_Q_W   = 33;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

  // Square root: number of two-bit digits of a 64-bit radicand.
  localparam int SQ_W     = 64;
  localparam int ROOT_W   = 32;
  localparam int SQ_CNT_W = $clog2(ROOT_W);

  typedef struct packed {
    logic busy;
    logic done;
  } bsfa_div_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EMIT,
    S_C2,
    S_RD,
    S_LOAD,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_CHK,
    S_DIVW,
    S_NXT,
    S_SC0,
    S_SC1,
    S_SC2,
    S_SC3,
    S_SQ0,
    S_SQ1,
    S_SQ2,
    S_SQ3,
    S_SQI,
    S_SQRT,
    S_DIRST,
    S_DIRW
  } bsfa_state_e;

endpackage

/* rtl/bsfa_if.sv */
// ----------------------------------------------------------------------------
// bsfa_if: command and result channels of the field accumulator
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface bsfa_in_if;
  import bsfa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [AMPS_W-1:0] wire_amps;

  modport source (output valid, command, pos_x, pos_y, wire_amps, input ready);
  modport sink   (input valid, command, pos_x, pos_y, wire_amps, output ready);
endinterface

interface bsfa_out_if;
  import bsfa_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [FIELD_W-1:0] field_x;
  logic signed [FIELD_W-1:0] field_y;
  logic [MAG_W-1:0]          field_magnitude;
  logic signed [DIR_W-1:0]   dir_x;
  logic signed [DIR_W-1:0]   dir_y;

  modport source (output valid, status, field_x, field_y, field_magnitude, dir_x, dir_y,
                  input ready);
  modport sink   (input valid, status, field_x, field_y, field_magnitude, dir_x, dir_y,
                  output ready);
endinterface

/* rtl/bsfa_ram.sv */
// ----------------------------------------------------------------------------
// bsfa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bsfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/bsfa_div.sv */
// ----------------------------------------------------------------------------
// bsfa_div: two-lane restoring divider with a shared divisor
// Divides two unsigned numerators by one divisor, one quotient bit per
// cycle in each lane. The quotient must fit in DIV_Q_W bits.
// ----------------------------------------------------------------------------
module bsfa_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bsfa_pkg::DIV_NUM_W-1:0] num_x_i,
  input  logic [bsfa_pkg::DIV_NUM_W-1:0] num_y_i,
  input  logic [bsfa_pkg::DIV_DEN_W-1:0] den_i,
  output bsfa_pkg::bsfa_div_stat_t       stat_o,
  output logic [bsfa_pkg::DIV_Q_W-1:0]   quo_x_o,
  output logic [bsfa_pkg::DIV_Q_W-1:0]   quo_y_o
);
  import bsfa_pkg::*;

  typedef struct packed {
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_Q_W-1:0]   lo;
  } lane_t;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_DEN_W-1:0] den_q;
  lane_t                lx_q, ly_q;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  function automatic lane_t div_step(lane_t l, logic [DIV_DEN_W-1:0] den);
    logic [DIV_DEN_W:0] t;
    logic               ge;
    lane_t              r;
    t     = {l.rem, l.lo[DIV_Q_W-1]};
    ge    = (t >= {1'b0, den});
    r.rem = ge ? DIV_DEN_W'(t - {1'b0, den}) : t[DIV_DEN_W-1:0];
    r.lo  = {l.lo[DIV_Q_W-2:0], ge};
    return r;
  endfunction

  // Control: count the quotient bits and flag the last one.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_Q_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath: the high numerator bits seed the partial remainder.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q   <= den_i;
      lx_q.rem <= DIV_DEN_W'(num_x_i[DIV_NUM_W-1:DIV_Q_W]);
      lx_q.lo  <= num_x_i[DIV_Q_W-1:0];
      ly_q.rem <= DIV_DEN_W'(num_y_i[DIV_NUM_W-1:DIV_Q_W]);
      ly_q.lo  <= num_y_i[DIV_Q_W-1:0];
    end else if (busy_q) begin
      lx_q <= div_step(lx_q, den_q);
      ly_q <= div_step(ly_q, den_q);
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_x_o     = lx_q.lo;
  assign quo_y_o     = ly_q.lo;

endmodule

/* rtl/biot_savart_field_accumulator.sv */
// ----------------------------------------------------------------------------
// biot_savart_field_accumulator: field of a table of straight line currents
// Stores wires, and for a query point sums, scales and normalizes the field.
// ----------------------------------------------------------------------------
// Add, clear and unused commands go straight to state S_EMIT, which loads their
// result into the output register once it is free. For a query each stored
// wire is read from the wire RAM, goes through four passes of the shared
// multiplier and then through the two-lane divider, which produces one
// quotient bit per cycle. A wire inside the cutoff skips the divider.
// After the sum, the multiplier scales and squares the field, a digit-serial
// square root forms the magnitude and the divider forms the direction. Only
// one command is in work at a time; the result sits in an output register so
// the next command may be taken while it waits.
module biot_savart_field_accumulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bsfa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  bsfa_in_if.sink                         in_ch,
  bsfa_out_if.source                      out_ch
);
  import bsfa_pkg::*;

  bsfa_state_e state_q, state_d;

  logic [SCALE_W-1:0]       scale_q;
  logic [CUT_W-1:0]         cutoff_q;
  logic [CNT_W-1:0]         count_q;
  logic [CNT_W-1:0]         idx_q;
  logic signed [POS_W-1:0]  px_q, py_q;
  logic [2*CUT_W-1:0]       c2_q;
  logic signed [POS_W:0]    dx_q, dy_q;
  logic signed [AMPS_W-1:0] cur_q;
  logic [DIV_DEN_W-1:0]     r2_q;
  logic signed [31:0]       ny_q, nx_q;
  logic signed [40:0]       sx_q, sy_q;
  logic [41:0]              t_q;
  logic signed [FIELD_W-1:0] fx_q, fy_q;
  logic                     sat_q;
  logic [SQ_W-1:0]          sq_q, sqv_q;
  logic [ROOT_W+2:0]        rem_q;
  logic [ROOT_W-1:0]        root_q;
  logic [SQ_CNT_W-1:0]      sq_cnt_q;
  logic [MAG_W-1:0]         mag_q;
  logic signed [DIR_W-1:0]  dirx_q, diry_q;
  logic [STATUS_W-1:0]      res_status_q;

  logic                      out_valid_q;
  logic [STATUS_W-1:0]       out_status_q;
  logic signed [FIELD_W-1:0] out_fx_q, out_fy_q;
  logic [MAG_W-1:0]          out_mag_q;
  logic signed [DIR_W-1:0]   out_dx_q, out_dy_q;

  // Control outputs of the sequencer.
  logic                   in_fire;
  logic                   can_emit;
  logic                   ram_we;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic signed [32:0]     mul_a;
  logic signed [17:0]     mul_b;
  logic signed [50:0]     mul_p;
  logic                   div_start;
  logic [DIV_NUM_W-1:0]   div_num_x, div_num_y;
  logic [DIV_DEN_W-1:0]   div_den;
  bsfa_div_stat_t         div_stat;
  logic [DIV_Q_W-1:0]     quo_x, quo_y;

  // Derived values used by several states.
  logic                   r2_skip;
  logic [39:0]            magx, magy;
  logic [ROOT_W-1:0]      ax, ay;
  logic [30:0]            any_abs, anx_abs;
  logic [ROOT_W+3:0]      sq_r, sq_trial;
  logic                   sq_ge;
  logic                   add_ok;

  typedef struct packed {
    logic signed [FIELD_W-1:0] val;
    logic                      sat;
  } clamp_t;

  // Scaled magnitude to a signed 32-bit value with saturation.
  function automatic clamp_t clamp32(logic [41:0] q, logic neg);
    clamp_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (q > 42'h0_8000_0000) begin
        r.sat = 1'b1;
        r.val = 32'sh8000_0000;
      end else begin
        r.val = FIELD_W'(-q);
      end
    end else begin
      if (q > 42'h0_7FFF_FFFF) begin
        r.sat = 1'b1;
        r.val = 32'sh7FFF_FFFF;
      end else begin
        r.val = q[FIELD_W-1:0];
      end
    end
    return r;
  endfunction

  // Unsigned direction quotient to a signed Q1.14 value.
  function automatic logic signed [DIR_W-1:0] dir_val(logic [DIV_Q_W-1:0] q, logic neg);
    logic [DIR_W-1:0] m;
    m = (q > DIV_Q_W'(16384)) ? DIR_W'(16384) : q[DIR_W-1:0];
    return neg ? -m : m;
  endfunction

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign can_emit = !out_valid_q || out_ch.ready;
  assign add_ok   = count_q < CNT_W'(MAX_WIRES);
  assign ram_we   = in_fire && (in_ch.command == CMD_ADD) && add_ok;

  assign r2_skip  = (r2_q == '0) || (r2_q < DIV_DEN_W'(c2_q));
  assign magx     = 40'(sx_q[40] ? -sx_q : sx_q);
  assign magy     = 40'(sy_q[40] ? -sy_q : sy_q);
  assign ax       = fx_q[FIELD_W-1] ? ROOT_W'(-fx_q) : ROOT_W'(fx_q);
  assign ay       = fy_q[FIELD_W-1] ? ROOT_W'(-fy_q) : ROOT_W'(fy_q);
  assign any_abs  = 31'(ny_q[31] ? -ny_q : ny_q);
  assign anx_abs  = 31'(nx_q[31] ? -nx_q : nx_q);
  assign mul_p    = mul_a * mul_b;

  // Square root digit step.
  assign sq_r     = {rem_q[ROOT_W+1:0], sqv_q[SQ_W-1:SQ_W-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_r >= sq_trial;

  // Wire table.
  bsfa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_WIRES)
  ) u_wire_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i({in_ch.pos_x, in_ch.pos_y, in_ch.wire_amps}),
    .raddr_i(idx_q[IDX_W-1:0]),
    .rdata_o(ram_rdata)
  );

  // Shared divide unit for the field terms and the direction.
  bsfa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_x_i(div_num_x),
    .num_y_i(div_num_y),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quo_x_o(quo_x),
    .quo_y_o(quo_y)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_ch.command == CMD_QUERY) ? S_C2 : S_EMIT;
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          state_d = S_IDLE;
        end
      end
      S_C2:   state_d = (count_q == '0) ? S_SC0 : S_RD;
      S_RD:   state_d = S_LOAD;
      S_LOAD: state_d = S_M0;
      S_M0:   state_d = S_M1;
      S_M1:   state_d = S_M2;
      S_M2:   state_d = S_M3;
      S_M3:   state_d = S_CHK;
      S_CHK:  state_d = r2_skip ? S_NXT : S_DIVW;
      S_DIVW: begin
        if (div_stat.done) begin
          state_d = S_NXT;
        end
      end
      S_NXT:  state_d = (idx_q + 1'b1 == count_q) ? S_SC0 : S_RD;
      S_SC0:  state_d = S_SC1;
      S_SC1:  state_d = S_SC2;
      S_SC2:  state_d = S_SC3;
      S_SC3:  state_d = S_SQ0;
      S_SQ0:  state_d = S_SQ1;
      S_SQ1:  state_d = S_SQ2;
      S_SQ2:  state_d = S_SQ3;
      S_SQ3:  state_d = S_SQI;
      S_SQI:  state_d = S_SQRT;
      S_SQRT: begin
        if (sq_cnt_q == SQ_CNT_W'(ROOT_W - 1)) begin
          state_d = S_DIRST;
        end
      end
      S_DIRST: state_d = (root_q == '0) ? S_EMIT : S_DIRW;
      S_DIRW: begin
        if (div_stat.done) begin
          state_d = S_EMIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands and divider launch.
  always_comb begin
    in_ch.ready = (state_q == S_IDLE);
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num_x   = {1'b0, any_abs, 18'b0};
    div_num_y   = {1'b0, anx_abs, 18'b0};
    div_den     = r2_q;
    unique case (state_q)
      S_C2: begin
        mul_a = 33'(cutoff_q);
        mul_b = 18'(cutoff_q);
      end
      S_M0: begin
        mul_a = 33'(dx_q);
        mul_b = 18'(dx_q);
      end
      S_M1: begin
        mul_a = 33'(dy_q);
        mul_b = 18'(dy_q);
      end
      S_M2: begin
        mul_a = 33'(dy_q);
        mul_b = 18'(cur_q);
      end
      S_M3: begin
        mul_a = 33'(dx_q);
        mul_b = 18'(cur_q);
      end
      S_CHK: begin
        div_start = !r2_skip;
      end
      S_SC0: begin
        mul_a = 33'({1'b0, magx[39:16]});
        mul_b = 18'({1'b0, scale_q});
      end
      S_SC1: begin
        mul_a = 33'({1'b0, magx[15:0]});
        mul_b = 18'({1'b0, scale_q});
      end
      S_SC2: begin
        mul_a = 33'({1'b0, magy[39:16]});
        mul_b = 18'({1'b0, scale_q});
      end
      S_SC3: begin
        mul_a = 33'({1'b0, magy[15:0]});
        mul_b = 18'({1'b0, scale_q});
      end
      S_SQ0: begin
        mul_a = {1'b0, ax};
        mul_b = 18'({1'b0, ax[31:16]});
      end
      S_SQ1: begin
        mul_a = {1'b0, ax};
        mul_b = 18'({1'b0, ax[15:0]});
      end
      S_SQ2: begin
        mul_a = {1'b0, ay};
        mul_b = 18'({1'b0, ay[31:16]});
      end
      S_SQ3: begin
        mul_a = {1'b0, ay};
        mul_b = 18'({1'b0, ay[15:0]});
      end
      S_DIRST: begin
        div_start = (root_q != '0);
        div_num_x = DIV_NUM_W'({ax, 14'b0});
        div_num_y = DIV_NUM_W'({ay, 14'b0});
        div_den   = DIV_DEN_W'(root_q);
      end
      default: begin
      end
    endcase
  end

  // Control registers: state, configuration, table fill and walk index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scale_q     <= SCALE_RESET;
      cutoff_q    <= CUTOFF_RESET;
      count_q     <= '0;
      idx_q       <= '0;
      sq_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FIELD_SCALE: scale_q  <= cfg_wdata_i[SCALE_W-1:0];
          CFG_CUTOFF:      cutoff_q <= cfg_wdata_i[CUT_W-1:0];
          default: begin
          end
        endcase
      end
      if (ram_we) begin
        count_q <= count_q + 1'b1;
      end else if (in_fire && in_ch.command == CMD_CLEAR) begin
        count_q <= '0;
      end
      if (in_fire) begin
        idx_q <= '0;
      end else if (state_q == S_NXT) begin
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == S_SQI) begin
        sq_cnt_q <= '0;
      end else if (state_q == S_SQRT) begin
        sq_cnt_q <= sq_cnt_q + 1'b1;
      end
      if (state_q == S_EMIT && can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    clamp_t cl;
    cl = clamp32(t_q + 42'(mul_p[31:16]), (state_q == S_SC1) ? sx_q[40] : sy_q[40]);
    unique case (state_q)
      S_IDLE: begin
        px_q         <= in_ch.pos_x;
        py_q         <= in_ch.pos_y;
        sx_q         <= '0;
        sy_q         <= '0;
        sat_q        <= 1'b0;
        fx_q         <= '0;
        fy_q         <= '0;
        mag_q        <= '0;
        dirx_q       <= '0;
        diry_q       <= '0;
        res_status_q <= (in_ch.command == CMD_ADD && !add_ok) ? STATUS_FULL : STATUS_OK;
      end
      S_C2:   c2_q <= mul_p[2*CUT_W-1:0];
      S_LOAD: begin
        dx_q  <= (POS_W+1)'(px_q) - (POS_W+1)'($signed(ram_rdata[ENTRY_W-1 -: POS_W]));
        dy_q  <= (POS_W+1)'(py_q) - (POS_W+1)'($signed(ram_rdata[AMPS_W +: POS_W]));
        cur_q <= ram_rdata[AMPS_W-1:0];
      end
      S_M0:   r2_q <= DIV_DEN_W'(mul_p[33:0]);
      S_M1:   r2_q <= r2_q + DIV_DEN_W'(mul_p[33:0]);
      S_M2:   ny_q <= mul_p[31:0];
      S_M3:   nx_q <= mul_p[31:0];
      S_DIVW: begin
        if (div_stat.done) begin
          // The x term has the sign of -dy*I, the y term that of dx*I.
          if (!ny_q[31] && ny_q != '0) begin
            sx_q <= sx_q - 41'(quo_x);
          end else begin
            sx_q <= sx_q + 41'(quo_x);
          end
          if (nx_q[31]) begin
            sy_q <= sy_q - 41'(quo_y);
          end else begin
            sy_q <= sy_q + 41'(quo_y);
          end
        end
      end
      S_SC0, S_SC2: t_q <= mul_p[41:0];
      S_SC1: begin
        fx_q  <= cl.val;
        sat_q <= sat_q | cl.sat;
      end
      S_SC3: begin
        fy_q  <= cl.val;
        sat_q <= sat_q | cl.sat;
      end
      S_SQ0: sq_q <= {1'b0, mul_p[46:0], 16'b0};
      S_SQ1, S_SQ3: sq_q <= sq_q + SQ_W'(mul_p[46:0]);
      S_SQ2: sq_q <= sq_q + {1'b0, mul_p[46:0], 16'b0};
      S_SQI: begin
        sqv_q  <= sq_q;
        rem_q  <= '0;
        root_q <= '0;
      end
      S_SQRT: begin
        rem_q  <= sq_ge ? (ROOT_W+3)'(sq_r - sq_trial) : sq_r[ROOT_W+2:0];
        root_q <= {root_q[ROOT_W-2:0], sq_ge};
        sqv_q  <= {sqv_q[SQ_W-3:0], 2'b00};
      end
      S_DIRST: begin
        if (root_q[ROOT_W-1]) begin
          mag_q <= '1;
        end else begin
          mag_q <= root_q[MAG_W-1:0];
        end
        res_status_q <= (sat_q || root_q[ROOT_W-1]) ? STATUS_SAT : STATUS_OK;
      end
      S_DIRW: begin
        if (div_stat.done) begin
          dirx_q <= dir_val(quo_x, fx_q[FIELD_W-1]);
          diry_q <= dir_val(quo_y, fy_q[FIELD_W-1]);
        end
      end
      default: begin
      end
    endcase
    // Output register, loaded when the previous result has moved on.
    if (state_q == S_EMIT && can_emit) begin
      out_status_q <= res_status_q;
      out_fx_q     <= fx_q;
      out_fy_q     <= fy_q;
      out_mag_q    <= mag_q;
      out_dx_q     <= dirx_q;
      out_dy_q     <= diry_q;
    end
  end

  assign out_ch.valid           = out_valid_q;
  assign out_ch.status          = out_status_q;
  assign out_ch.field_x         = out_fx_q;
  assign out_ch.field_y         = out_fy_q;
  assign out_ch.field_magnitude = out_mag_q;
  assign out_ch.dir_x           = out_dx_q;
  assign out_ch.dir_y           = out_dy_q;

  // Checks on the sequencer and the wire table.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_WIRES))
    else $error("wire count beyond table size");

  a_add_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted add did not grow the table");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider launched while busy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_ch.command == CMD_ADD && !add_ok) |=> res_status_q == STATUS_FULL)
    else $error("dropped add not flagged");

endmodule

/* tb/bsfa_field_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfa_field_checker: result predictor and scoreboard of the field accumulator
// Watches the configuration port and both channels. Each command transfer is
// run through a local model of the wire table and the field arithmetic, and
// each result transfer is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bsfa_field_checker
  import bsfa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bsfa_in_if                    in_mon,
  bsfa_out_if                   out_mon,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  field_x;
    logic [FIELD_W-1:0]  field_y;
    logic [MAG_W-1:0]    magnitude;
    logic [DIR_W-1:0]    dir_x;
    logic [DIR_W-1:0]    dir_y;
  } field_result_t;

  // Local copy of the registers and of the wire table.
  logic [SCALE_W-1:0] scale_reg;
  logic [CUT_W-1:0]   cutoff_reg;
  longint             wire_x_tab  [MAX_WIRES];
  longint             wire_y_tab  [MAX_WIRES];
  longint             wire_amp_tab[MAX_WIRES];
  int                 wire_total;

  field_result_t expected_fields[$];

  assign pending_o = expected_fields.size();

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b   = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Truncating scale by k / 2^16, clamped to the signed 32-bit range.
  function automatic longint scale_field(longint s, logic [SCALE_W-1:0] k, inout bit sat);
    bit          neg;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] kk;
    neg = s < 0;
    kk  = 64'(k);
    mag = neg ? 64'(-s) : 64'(s);
    q   = (mag >> 16) * kk + (((mag & 64'hFFFF) * kk) >> 16);
    if (neg) begin
      if (q > 64'd2147483648) begin
        sat = 1'b1;
        q   = 64'd2147483648;
      end
      return -longint'(q);
    end
    if (q > 64'd2147483647) begin
      sat = 1'b1;
      q   = 64'd2147483647;
    end
    return longint'(q);
  endfunction

  function automatic longint unit_component(longint f, logic [63:0] m);
    longint d;
    if (m == 0) return 0;
    d = (f * 16384) / longint'(m);
    if (d > 16384) d = 16384;
    if (d < -16384) d = -16384;
    return d;
  endfunction

  // Field at a point from all wires in the table outside the cutoff.
  function automatic field_result_t field_at_point(longint px, longint py);
    field_result_t r;
    longint        sx, sy, dx, dy, r2, c2, fx, fy, ux, uy;
    logic [63:0]   ax, ay, m;
    bit            sat;
    sx  = 0;
    sy  = 0;
    sat = 1'b0;
    c2  = longint'(cutoff_reg) * longint'(cutoff_reg);
    for (int i = 0; i < wire_total; i++) begin
      dx = px - wire_x_tab[i];
      dy = py - wire_y_tab[i];
      r2 = dx * dx + dy * dy;
      if (r2 != 0 && r2 >= c2) begin
        sx += ((-dy) * wire_amp_tab[i] * 262144) / r2;
        sy += (dx * wire_amp_tab[i] * 262144) / r2;
      end
    end
    fx = scale_field(sx, scale_reg, sat);
    fy = scale_field(sy, scale_reg, sat);
    ax = fx < 0 ? 64'(-fx) : 64'(fx);
    ay = fy < 0 ? 64'(-fy) : 64'(fy);
    m  = floor_sqrt(ax * ax + ay * ay);
    ux = unit_component(fx, m);
    uy = unit_component(fy, m);
    if (m > 64'd2147483647) begin
      sat = 1'b1;
      r.magnitude = 31'h7FFFFFFF;
    end else begin
      r.magnitude = m[MAG_W-1:0];
    end
    r.status  = sat ? STATUS_SAT : STATUS_OK;
    r.field_x = fx[FIELD_W-1:0];
    r.field_y = fy[FIELD_W-1:0];
    r.dir_x   = ux[DIR_W-1:0];
    r.dir_y   = uy[DIR_W-1:0];
    return r;
  endfunction

  // Configuration writes, command transfers and result transfers.
  always @(posedge clk_i or negedge rst_ni) begin
    field_result_t r;
    field_result_t want;
    if (!rst_ni) begin
      scale_reg    <= SCALE_RESET;
      cutoff_reg   <= CUTOFF_RESET;
      wire_total   = 0;
      fail_count_o = 0;
      expected_fields.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FIELD_SCALE) scale_reg <= cfg_wdata_i[SCALE_W-1:0];
        else if (cfg_idx_i == CFG_CUTOFF) cutoff_reg <= cfg_wdata_i[CUT_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        r = '{default: '0};
        case (in_mon.command)
          CMD_ADD: begin
            if (wire_total < MAX_WIRES) begin
              wire_x_tab[wire_total]   = longint'(in_mon.pos_x);
              wire_y_tab[wire_total]   = longint'(in_mon.pos_y);
              wire_amp_tab[wire_total] = longint'(in_mon.wire_amps);
              wire_total++;
            end else begin
              r.status = STATUS_FULL;
            end
          end
          CMD_CLEAR: wire_total = 0;
          CMD_QUERY: r = field_at_point(longint'(in_mon.pos_x), longint'(in_mon.pos_y));
          default: ;
        endcase
        expected_fields = {expected_fields, r};
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: result transfer with no command outstanding", $time);
          fail_count_o++;
        end else begin
          want = expected_fields.pop_front();
          if (out_mon.status !== want.status)
            report_mismatch("status", out_mon.status, want.status);
          if (out_mon.field_x !== want.field_x)
            report_mismatch("field_x", out_mon.field_x, $signed(want.field_x));
          if (out_mon.field_y !== want.field_y)
            report_mismatch("field_y", out_mon.field_y, $signed(want.field_y));
          if (out_mon.field_magnitude !== want.magnitude)
            report_mismatch("field_magnitude", out_mon.field_magnitude, want.magnitude);
          if (out_mon.dir_x !== want.dir_x)
            report_mismatch("dir_x", out_mon.dir_x, $signed(want.dir_x));
          if (out_mon.dir_y !== want.dir_y)
            report_mismatch("dir_y", out_mon.dir_y, $signed(want.dir_y));
        end
      end
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the line-current field accumulator
// Runs a directed set of wire, clear and query commands over register
// extremes, then random phases of mostly well-formed table builds and queries
// with random gaps and result stalls. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module testbench;
  import bsfa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    results_pending;
  bit                    calm;
  int                    stall_left;

  bsfa_in_if  in_ch ();
  bsfa_out_if out_ch ();

  biot_savart_field_accumulator i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  bsfa_field_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (results_pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Result side back-pressure: mostly ready, short stalls, a few long ones.
  always @(posedge clk_i) begin
    int r;
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (!calm && r < 2) stall_left <= $urandom_range(20, 80);
      else if (!calm && r < 20) stall_left <= $urandom_range(1, 3);
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // One command transfer, after an optional idle gap.
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] x,
                          logic [POS_W-1:0] y, logic [AMPS_W-1:0] amps);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.pos_x     <= x;
    in_ch.pos_y     <= y;
    in_ch.wire_amps <= amps;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // The first edge lets the checker record the last command transfer.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  // Writes both registers while the block is idle.
  task automatic set_regs(logic [SCALE_W-1:0] scale, logic [CUT_W-1:0] cutoff);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FIELD_SCALE;
    cfg_wdata <= scale;
    @(posedge clk_i);
    cfg_idx   <= CFG_CUTOFF;
    cfg_wdata <= CFG_DATA_W'(cutoff);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    if ($urandom_range(0, 9) == 0) return POS_W'($urandom);
    return POS_W'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic [AMPS_W-1:0] rand_amps();
    if ($urandom_range(0, 9) == 0) return AMPS_W'($urandom);
    return AMPS_W'($urandom_range(0, 24576) - 12288);
  endfunction

  // Timeout guard.
  initial begin
    #100000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int r;
    int phase_len;
    in_ch.valid     <= 1'b0;
    in_ch.command   <= CMD_ADD;
    in_ch.pos_x     <= '0;
    in_ch.pos_y     <= '0;
    in_ch.wire_amps <= '0;
    cfg_we          <= 1'b0;
    cfg_idx         <= CFG_FIELD_SCALE;
    cfg_wdata       <= '0;
    stall_left      <= 0;
    calm            = 1'b1;
    rst_ni          = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, wire at the query point, unused command.
    send_cmd(CMD_QUERY, 16'sd0, 16'sd0, '0);
    send_cmd(CMD_ADD, 16'sd16384, 16'sd16384, 15'sd12288);
    send_cmd(CMD_ADD, -16'sd16384, -16'sd16384, -15'sd12288);
    send_cmd(CMD_QUERY, 16'sd16384, 16'sd16384, '0);
    send_cmd(CMD_QUERY, 16'sd0, 16'sd100, 15'sd5);
    send_cmd(CMD_QUERY, 16'h7FFF, 16'h8000, '0);
    send_cmd(CMD_UNUSED, 16'h7FFF, 16'h7FFF, 15'h3FFF);
    send_cmd(CMD_CLEAR, '0, '0, '0);
    send_cmd(CMD_QUERY, 16'sd16384, 16'sd16384, '0);

    // Saturation with full scale and no cutoff; zero distance still skipped.
    set_regs(16'hFFFF, 15'd0);
    send_cmd(CMD_ADD, 16'sd0, 16'sd0, 15'sd12288);
    send_cmd(CMD_ADD, 16'sd3, 16'sd0, -15'sd12288);
    send_cmd(CMD_QUERY, 16'sd1, 16'sd0, '0);
    send_cmd(CMD_QUERY, 16'sd0, 16'sd0, '0);
    send_cmd(CMD_QUERY, 16'sd0, 16'sd1, '0);
    send_cmd(CMD_CLEAR, '0, '0, '0);

    // Zero scale and the widest cutoff.
    set_regs(16'd0, 15'h7FFF);
    send_cmd(CMD_ADD, 16'sd100, -16'sd200, 15'sd4096);
    send_cmd(CMD_QUERY, 16'sd0, 16'sd0, '0);
    send_cmd(CMD_QUERY, -16'sd16384, 16'sd16384, '0);
    send_cmd(CMD_CLEAR, '0, '0, '0);

    // Random phases over several register settings.
    calm = 1'b0;
    for (int phase = 0; phase < 11; phase++) begin
      case (phase % 5)
        0: set_regs(SCALE_RESET, CUTOFF_RESET);
        1: set_regs(16'hFFFF, 15'd0);
        2: set_regs(16'($urandom), 15'($urandom_range(0, 2000)));
        3: set_regs(16'd1, 15'h7FFF);
        default: set_regs(16'($urandom_range(0, 4000)), 15'($urandom_range(0, 700)));
      endcase
      calm = (phase == 6);
      send_cmd(CMD_CLEAR, rand_pos(), rand_pos(), rand_amps());
      phase_len = 100;
      if (phase % 4 == 2) begin
        // Fill the table past its end, then query the full table.
        for (int i = 0; i < MAX_WIRES + 3; i++)
          send_cmd(CMD_ADD, rand_pos(), rand_pos(), rand_amps());
        phase_len = 30;
      end
      for (int i = 0; i < phase_len; i++) begin
        if (i == phase_len / 2) drain_results();
        r = $urandom_range(0, 99);
        if (phase % 4 == 2 || (r >= 50 && r < 87))
          send_cmd(CMD_QUERY, rand_pos(), rand_pos(), rand_amps());
        else if (r < 50) send_cmd(CMD_ADD, rand_pos(), rand_pos(), rand_amps());
        else if (r < 96) send_cmd(CMD_CLEAR, rand_pos(), rand_pos(), rand_amps());
        else send_cmd(CMD_UNUSED, rand_pos(), rand_pos(), rand_amps());
      end
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
